// File: design/mkpm_pkg.sv
// shared types, constants and helpers for the multi-key prefix matcher
// no dependencies
package mkpm_pkg;

  localparam int unsigned NUM_KEYS_DEF = 16;
  localparam int unsigned KEY_LEN_DEF  = 32;

  localparam int unsigned MASK_W  = 16;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_MASK = 1'd1;

  localparam logic [1:0] MODE_KEY_BYTE = 2'd0;
  localparam logic [1:0] MODE_KEY_LEN  = 2'd1;
  localparam logic [1:0] MODE_TEXT     = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] key_index;
    logic [4:0] position;
    logic [7:0] byte_value;
    logic       first;
    logic       final_req;
  } in_beat_t;

  typedef struct packed {
    logic [MASK_W-1:0] match_mask;
    logic              stopped_early;
  } out_beat_t;

  // ascii upper case to lower case
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: design/multi_key_prefix_matcher.sv
// multi-key prefix matcher: one byte per cycle; a result follows its input beat through the
// input register, then the result register; a new beat is taken every cycle unless a
// result is held by out_stall_i. key bytes live in one ram per key, prefetched at the
// next match position. reset clears key lengths, match state and config at once;
// key bytes are undefined until loaded, and there is no clearing pass
// top level, uses mkpm_pkg and mkpm_ram
module multi_key_prefix_matcher #(
  parameter int unsigned NUM_KEYS = mkpm_pkg::NUM_KEYS_DEF,
  parameter int unsigned KEY_LEN  = mkpm_pkg::KEY_LEN_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mkpm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mkpm_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  mkpm_pkg::in_beat_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output mkpm_pkg::out_beat_t                  out_data_o
);
  import mkpm_pkg::*;

  localparam int unsigned AW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
  localparam int unsigned PW = $clog2(KEY_LEN + 1);

  // config
  logic [COUNT_W-1:0] key_count_q;
  logic [MASK_W-1:0]  stop_mask_q;

  // input register
  logic     in_valid_q;
  in_beat_t in_q;

  // result register
  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;

  // per key state
  logic [PW-1:0] len_q [NUM_KEYS];
  logic [PW-1:0] pos_q [NUM_KEYS];
  logic [PW-1:0] pos_d [NUM_KEYS];
  logic [NUM_KEYS-1:0] dead_q, dead_d;
  logic [NUM_KEYS-1:0] found_q, found_d;
  logic done_q, done_d;

  // key byte storage
  logic [7:0]          byte0_q [NUM_KEYS];
  logic [7:0]          rdata [NUM_KEYS];
  logic [AW-1:0]       rd_addr [NUM_KEYS];
  logic [NUM_KEYS-1:0] wr_en;
  logic [AW-1:0]       wr_addr;
  logic [NUM_KEYS-1:0] byp_q;
  logic [7:0]          byp_data_q;

  logic proc_go, text_go, res_valid, stop_hit;
  logic [PW-1:0] len_in;

  assign proc_go    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc_go;
  assign text_go    = proc_go && (in_q.mode == MODE_TEXT);
  assign wr_addr    = AW'(in_q.position);
  assign len_in     = ({1'b0, in_q.byte_value} > 9'(KEY_LEN)) ? PW'(KEY_LEN)
                                                               : PW'(in_q.byte_value);

  always_comb begin
    for (int x = 0; x < NUM_KEYS; x++) begin
      wr_en[x] = proc_go && (in_q.mode == MODE_KEY_BYTE) &&
                 (int'(in_q.key_index) == x) && (int'(in_q.position) < KEY_LEN);
    end
  end

  always_comb begin : match_logic
    logic          first_v, done_e, blocked, full, dead_n;
    logic [PW-1:0] pos_e, pos_n, next_p;
    logic [7:0]    kb, tb;
    logic [31:0]   stop_ext;
    logic [NUM_KEYS-1:0] found_n;
    first_v  = in_q.first;
    done_e   = first_v ? 1'b0 : done_q;
    tb       = fold_case(in_q.byte_value);
    stop_ext = 32'(stop_mask_q);
    blocked  = 1'b0;
    found_n  = first_v ? '0 : found_q;
    for (int x = 0; x < NUM_KEYS; x++) begin
      pos_e  = first_v ? '0 : pos_q[x];
      dead_n = first_v ? 1'b0 : dead_q[x];
      pos_n  = pos_e;
      next_p = pos_e + PW'(1);
      full   = 1'b0;
      kb     = first_v ? byte0_q[x] : (byp_q[x] ? byp_data_q : rdata[x]);
      if ((x < int'(key_count_q)) && !blocked) begin
        if (dead_n || pos_e >= len_q[x] || fold_case(kb) != tb) begin
          dead_n = 1'b1;
        end else if (next_p == len_q[x]) begin
          pos_n = '0;
          full  = 1'b1;
        end else begin
          pos_n = next_p;
        end
      end
      if (full) begin
        found_n[x] = 1'b1;
        if (stop_ext[x]) begin
          blocked = 1'b1;
        end
      end
      if (text_go && !done_e) begin
        pos_d[x]  = pos_n;
        dead_d[x] = dead_n;
      end else begin
        pos_d[x]  = pos_q[x];
        dead_d[x] = dead_q[x];
      end
    end
    stop_hit  = blocked;
    res_valid = text_go && !done_e && (blocked || in_q.final_req);
    found_d   = (text_go && !done_e) ? found_n : found_q;
    done_d    = text_go ? (done_e || res_valid) : done_q;
  end

  always_comb begin
    out_d.match_mask    = MASK_W'(found_d);
    out_d.stopped_early = stop_hit;
    if (proc_go) begin
      out_valid_d = res_valid;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
    assign rd_addr[g] = AW'(pos_d[g]);

    mkpm_ram #(
      .WIDTH(8),
      .DEPTH(KEY_LEN)
    ) u_key_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en[g]),
      .waddr_i(wr_addr),
      .wdata_i(in_q.byte_value),
      .raddr_i(rd_addr[g]),
      .rdata_o(rdata[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      stop_mask_q <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dead_q      <= '0;
      found_q     <= '0;
      done_q      <= 1'b0;
      byp_q       <= '0;
      for (int x = 0; x < NUM_KEYS; x++) begin
        len_q[x] <= '0;
        pos_q[x] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY_COUNT: key_count_q <= cfg_data_i[COUNT_W-1:0];
          CFG_STOP_MASK: stop_mask_q <= cfg_data_i[MASK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (proc_go) begin
        in_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      dead_q      <= dead_d;
      found_q     <= found_d;
      done_q      <= done_d;
      for (int x = 0; x < NUM_KEYS; x++) begin
        pos_q[x] <= pos_d[x];
        byp_q[x] <= wr_en[x] && (wr_addr == rd_addr[x]);
        if (proc_go && in_q.mode == MODE_KEY_LEN && int'(in_q.key_index) == x) begin
          len_q[x] <= len_in;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (proc_go) begin
      out_q <= out_d;
    end
    byp_data_q <= in_q.byte_value;
    for (int x = 0; x < NUM_KEYS; x++) begin
      if (wr_en[x] && in_q.position == 5'd0) begin
        byte0_q[x] <= in_q.byte_value;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // a held result always belongs to a finished string
  a_result_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> done_q)
    else $error("result pending without string done");

  // an early stop always reports the stopping key
  a_stop_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.stopped_early) |-> (out_q.match_mask != '0))
    else $error("early stop with empty match mask");

  // input side only waits on a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without output back pressure");

  for (genvar a = 0; a < NUM_KEYS; a++) begin : g_chk
    a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      int'(pos_q[a]) < KEY_LEN)
      else $error("match position out of key range");
  end
`endif

endmodule

// File: design/mkpm_ram.sv
// generic single write port ram with registered read-first read port
// no dependencies
module mkpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: verif/multi_key_prefix_matcher_tb.sv
// testbench for multi_key_prefix_matcher: a directed table, then random key loads, strings, noise
// every result beat is checked against a predictor or a typed row; needs mkpm_pkg and the design
`timescale 1ns / 100ps

module multi_key_prefix_matcher_tb;
  import mkpm_pkg::*;

  localparam int NKEYS = NUM_KEYS_DEF;
  localparam int KLEN = KEY_LEN_DEF;
  localparam int LIMIT = 500000;
  localparam int TOTAL = 1450;
  localparam int CALM_FROM = 1250;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    bit        has;
    out_beat_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_beat_t out_data_o;

  // predictor state
  logic [7:0] key_mem [NKEYS][KLEN];
  logic [KLEN-1:0] key_written [NKEYS];
  logic [5:0] key_len [NKEYS];
  logic [5:0] match_pos [NKEYS];
  logic [NKEYS-1:0] key_dead;
  logic [MASK_W-1:0] found_keys;
  logic str_done;
  logic [COUNT_W-1:0] key_count_q;
  logic [MASK_W-1:0] stop_q;

  out_beat_t expected_matches[$];
  dir_row_t dir_rows[$];
  int err_count = 0;
  int beats_sent = 0;
  int cycles = 0;
  bit gap_en = 1'b0;
  bit hold_en = 1'b0;

  multi_key_prefix_matcher DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls in random bursts
  initial forever begin
    if (!hold_en || $urandom_range(0, 3) != 0) begin
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end else begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 16)) if (hold_en) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    out_beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_matches.size() == 0) begin
        $error("unexpected result beat: match_mask %h stopped_early %b",
               out_data_o.match_mask, out_data_o.stopped_early);
        err_count++;
      end else begin
        e = expected_matches.pop_front();
        if (out_data_o.match_mask !== e.match_mask) begin
          $error("match_mask: expected %h, actual %h", e.match_mask, out_data_o.match_mask);
          err_count++;
        end
        if (out_data_o.stopped_early !== e.stopped_early) begin
          $error("stopped_early: expected %b, actual %b", e.stopped_early,
                 out_data_o.stopped_early);
          err_count++;
        end
      end
    end
  end

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) return c + 8'h20;
    return c;
  endfunction

  function automatic int key_prefix(input int k);
    int n;
    n = 0;
    while (n < KLEN && key_written[k][n]) n++;
    return n;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      c = 8'h61 + 8'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) c = c ^ 8'h20;
    end else if (r == 6) begin
      case ($urandom_range(0, 5))
        0: c = 8'h40;
        1: c = 8'h5b;
        2: c = 8'h60;
        3: c = 8'h7b;
        4: c = 8'h00;
        default: c = 8'hff;
      endcase
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic in_beat_t mk_beat(input logic [1:0] m, input int k, input int p,
                                       input int v, input bit f, input bit l);
    in_beat_t b;
    b.mode = m;
    b.key_index = k[3:0];
    b.position = p[4:0];
    b.byte_value = v[7:0];
    b.first = f;
    b.final_req = l;
    return b;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] m, input int k, input int p,
                                      input int v, input bit f, input bit l,
                                      input bit typed = 1'b0, input bit has = 1'b0,
                                      input logic [MASK_W-1:0] mask = '0,
                                      input bit stp = 1'b0);
    dir_row_t row;
    row.beat = mk_beat(m, k, p, v, f, l);
    row.typed = typed;
    row.has = has;
    row.res.match_mask = mask;
    row.res.stopped_early = stp;
    return row;
  endfunction

  task automatic predict_match(input in_beat_t b, output bit has, output out_beat_t r);
    logic [7:0] c;
    logic [5:0] p;
    int n;
    has = 1'b0;
    r = '0;
    case (b.mode)
      MODE_KEY_BYTE: begin
        key_mem[b.key_index][b.position] = b.byte_value;
        key_written[b.key_index][b.position] = 1'b1;
      end
      MODE_KEY_LEN: begin
        key_len[b.key_index] = (b.byte_value > KLEN) ? 6'(KLEN) : b.byte_value[5:0];
      end
      MODE_TEXT: begin
        if (b.first) begin
          for (int x = 0; x < NKEYS; x++) match_pos[x] = '0;
          key_dead = '0;
          found_keys = '0;
          str_done = 1'b0;
        end
        if (!str_done) begin
          c = lower_ascii(b.byte_value);
          n = (key_count_q > NKEYS) ? NKEYS : int'(key_count_q);
          for (int x = 0; x < n && !has; x++) begin
            if (key_dead[x] || match_pos[x] >= key_len[x]) begin
              key_dead[x] = 1'b1;
            end else if (lower_ascii(key_mem[x][match_pos[x]]) != c) begin
              key_dead[x] = 1'b1;
            end else begin
              p = match_pos[x] + 6'd1;
              if (p == key_len[x]) begin
                p = '0;
                found_keys[x] = 1'b1;
                if (stop_q[x]) begin
                  str_done = 1'b1;
                  has = 1'b1;
                  r.match_mask = found_keys;
                  r.stopped_early = 1'b1;
                end
              end
              match_pos[x] = p;
            end
          end
          if (!has && b.final_req) begin
            str_done = 1'b1;
            has = 1'b1;
            r.match_mask = found_keys;
            r.stopped_early = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(input in_beat_t b, input bit typed = 1'b0, input bit t_has = 1'b0,
                           input out_beat_t t_res = '0);
    bit has;
    out_beat_t r;
    if (gap_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_match(b, has, r);
    if (typed) begin
      has = t_has;
      r = t_res;
    end
    if (has) expected_matches.push_back(r);
    if (b.mode != MODE_UNUSED) beats_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [COUNT_W-1:0] kc, input logic [MASK_W-1:0] sm);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_KEY_COUNT;
    cfg_data_i <= CFG_W'(kc);
    @(posedge clk_i);
    key_count_q = kc;
    cfg_idx_i <= CFG_STOP_MASK;
    cfg_data_i <= sm;
    @(posedge clk_i);
    stop_q = sm;
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_key(input int k, input int len);
    int lv;
    for (int i = 0; i < len; i++)
      send_beat(mk_beat(MODE_KEY_BYTE, k, i, pick_byte(), $urandom_range(0, 1),
                        $urandom_range(0, 1)));
    lv = (len == KLEN && $urandom_range(0, 1)) ? $urandom_range(KLEN + 1, 255) : len;
    send_beat(mk_beat(MODE_KEY_LEN, k, $urandom_range(0, 31), lv, $urandom_range(0, 1),
                      $urandom_range(0, 1)));
  endtask

  task automatic send_string();
    logic [7:0] txt[$];
    logic [7:0] ch;
    int n, k, at;
    bit nofirst, nofinal;
    n = (key_count_q > NKEYS) ? NKEYS : int'(key_count_q);
    repeat ($urandom_range(1, 3)) begin
      if (n > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, n - 1);
        at = txt.size();
        for (int i = 0; i < key_len[k]; i++) begin
          ch = key_mem[k][i];
          if ((ch | 8'h20) >= 8'h61 && (ch | 8'h20) <= 8'h7a && $urandom_range(0, 1))
            ch = ch ^ 8'h20;
          txt.push_back(ch);
        end
        if (txt.size() > at && $urandom_range(0, 7) == 0)
          txt[$urandom_range(at, txt.size() - 1)] = pick_byte();
      end else begin
        repeat ($urandom_range(1, 3)) txt.push_back(pick_byte());
      end
    end
    nofirst = ($urandom_range(0, 19) == 0);
    nofinal = ($urandom_range(0, 9) == 0);
    foreach (txt[i])
      send_beat(mk_beat(MODE_TEXT, $urandom_range(0, 15), $urandom_range(0, 31), txt[i],
                        i == 0 && !nofirst, i == txt.size() - 1 && !nofinal));
  endtask

  task automatic send_noise();
    in_beat_t b;
    int pr;
    b = mk_beat(2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 31),
                $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1));
    if (b.mode == MODE_KEY_LEN) begin
      // never let a key reach past its loaded bytes
      pr = key_prefix(b.key_index);
      if (pr == KLEN && $urandom_range(0, 1)) b.byte_value = 8'($urandom_range(KLEN + 1, 255));
      else b.byte_value = 8'($urandom_range(0, pr));
    end
    send_beat(b);
  endtask

  initial begin
    int len, phase_end, sel;
    logic [COUNT_W-1:0] kc;
    logic [MASK_W-1:0] sm;

    for (int x = 0; x < NKEYS; x++) begin
      for (int i = 0; i < KLEN; i++) key_mem[x][i] = '0;
      key_written[x] = '0;
      key_len[x] = '0;
      match_pos[x] = '0;
    end
    key_dead = '0;
    found_keys = '0;
    str_done = 1'b0;
    key_count_q = '0;
    stop_q = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_config(5'd3, 16'h0006);

    dir_rows.push_back(mk_row(MODE_TEXT, 0, 0, 8'h78, 0, 1, 1, 1, 16'h0000, 0));
    dir_rows.push_back(mk_row(MODE_TEXT, 0, 0, 8'h79, 0, 1, 1, 0));
    dir_rows.push_back(mk_row(MODE_UNUSED, 15, 31, 8'hff, 1, 1, 1, 0));
    dir_rows.push_back(mk_row(MODE_KEY_BYTE, 0, 0, 8'h41, 0, 0));
    dir_rows.push_back(mk_row(MODE_KEY_BYTE, 0, 1, 8'h7a, 0, 0));
    dir_rows.push_back(mk_row(MODE_KEY_LEN, 0, 0, 2, 0, 0));
    dir_rows.push_back(mk_row(MODE_KEY_BYTE, 2, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(MODE_KEY_LEN, 2, 0, 1, 0, 0));
    dir_rows.push_back(mk_row(MODE_TEXT, 0, 0, 8'h61, 1, 0));
    dir_rows.push_back(mk_row(MODE_TEXT, 0, 0, 8'h5a, 0, 0));
    dir_rows.push_back(mk_row(MODE_TEXT, 0, 0, 8'h41, 0, 1));
    dir_rows.push_back(mk_row(MODE_TEXT, 0, 0, 8'h00, 1, 1));
    dir_rows.push_back(mk_row(MODE_TEXT, 0, 0, 8'h00, 0, 1));
    dir_rows.push_back(mk_row(MODE_TEXT, 0, 0, 8'h61, 1, 0));
    dir_rows.push_back(mk_row(MODE_KEY_LEN, 0, 0, 1, 0, 0));
    dir_rows.push_back(mk_row(MODE_TEXT, 0, 0, 8'h61, 0, 1));
    dir_rows.push_back(mk_row(MODE_KEY_BYTE, 1, 0, 8'h00, 0, 0));
    dir_rows.push_back(mk_row(MODE_KEY_LEN, 1, 0, 1, 0, 0));
    dir_rows.push_back(mk_row(MODE_TEXT, 0, 0, 8'h00, 1, 1));
    dir_rows.push_back(mk_row(MODE_TEXT, 0, 0, 8'h61, 1, 0));
    dir_rows.push_back(mk_row(MODE_TEXT, 0, 0, 8'h41, 0, 1));
    dir_rows.push_back(mk_row(MODE_TEXT, 15, 31, 8'hff, 1, 1));
    dir_rows.push_back(mk_row(MODE_KEY_BYTE, 15, 31, 8'hff, 1, 1));

    foreach (dir_rows[i])
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].has, dir_rows[i].res);

    while (beats_sent < TOTAL) begin
      wait_idle();
      gap_en = (beats_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      hold_en = (beats_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0: kc = '0;
        1: kc = 5'(NKEYS);
        2: kc = 5'($urandom_range(NKEYS + 1, 31));
        default: kc = 5'($urandom_range(1, NKEYS));
      endcase
      case ($urandom_range(0, 4))
        0: sm = '0;
        1: sm = '1;
        2: sm = 16'(1) << $urandom_range(0, 15);
        default: sm = 16'($urandom_range(0, 65535));
      endcase
      set_config(kc, sm);
      phase_end = beats_sent + $urandom_range(60, 140);
      while (beats_sent < phase_end && beats_sent < TOTAL) begin
        if (beats_sent >= CALM_FROM) begin
          gap_en = 1'b0;
          hold_en = 1'b0;
        end
        sel = $urandom_range(0, 19);
        if (sel < 4) begin
          case ($urandom_range(0, 9))
            0: len = 0;
            7, 8: len = $urandom_range(5, 12);
            9: len = KLEN;
            default: len = $urandom_range(1, 4);
          endcase
          load_key($urandom_range(0, NKEYS - 1), len);
        end else if (sel < 18) begin
          send_string();
        end else begin
          send_noise();
        end
      end
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
